FILE: src/rvpm_pkg.sv
// package for the rotation vector to pose matrix block
// holds item types, fixed-point constants and the cordic angle table; no dependencies
package rvpm_pkg;

   typedef struct packed {
      logic signed [15:0] rot_x;
      logic signed [15:0] rot_y;
      logic signed [15:0] rot_z;
      logic signed [31:0] trans_x;
      logic signed [31:0] trans_y;
      logic signed [31:0] trans_z;
   } req_item_type;

   typedef struct packed {
      logic [1:0]         row_index;
      logic signed [31:0] col0;
      logic signed [31:0] col1;
      logic signed [31:0] col2;
      logic signed [31:0] col3;
      logic               last_row;
   } rsp_item_type;

   // q.30 constants, 36 bits signed holds every angle value
   localparam logic signed [35:0] ONE30       = 36'sd1073741824;
   localparam logic signed [35:0] PI30        = 36'sd3373259426;
   localparam logic signed [35:0] HALFPI30    = 36'sd1686629713;
   localparam logic signed [35:0] TWOPI30     = 36'sd6746518852;
   localparam logic signed [35:0] CORDIC_GAIN = 36'sh026DD3B6A;
   localparam int                 CORDIC_STEPS = 31;
   localparam int                 SQRT_STEPS   = 32;
   localparam int                 DIV_STEPS    = 31;
   localparam logic signed [31:0] Q16_ONE     = 32'sh00010000;

   function automatic logic signed [35:0] atan_entry(input logic [4:0] i);
      logic signed [35:0] r;
      begin
         case (i)
            5'd0:  r = 36'sh03243F6A8;
            5'd1:  r = 36'sh01DAC6705;
            5'd2:  r = 36'sh00FADBAFC;
            5'd3:  r = 36'sh007F56EA6;
            5'd4:  r = 36'sh003FEAB76;
            5'd5:  r = 36'sh001FFD55B;
            5'd6:  r = 36'sh000FFFAAA;
            5'd7:  r = 36'sh0007FFF55;
            5'd8:  r = 36'sh0003FFFEA;
            5'd9:  r = 36'sh0001FFFFD;
            5'd10: r = 36'sh0000FFFFF;
            5'd11: r = 36'sh00007FFFF;
            5'd12: r = 36'sh00003FFFF;
            5'd13: r = 36'sh00001FFFF;
            5'd14: r = 36'sh00000FFFF;
            5'd15: r = 36'sh000007FFF;
            5'd16: r = 36'sh000003FFF;
            5'd17: r = 36'sh000001FFF;
            5'd18: r = 36'sh000000FFF;
            5'd19: r = 36'sh0000007FF;
            5'd20: r = 36'sh0000003FF;
            5'd21: r = 36'sh0000001FF;
            5'd22: r = 36'sh0000000FF;
            5'd23: r = 36'sh00000007F;
            5'd24: r = 36'sh00000003F;
            5'd25: r = 36'sh00000001F;
            5'd26: r = 36'sh00000000F;
            5'd27: r = 36'sh000000008;
            5'd28: r = 36'sh000000004;
            5'd29: r = 36'sh000000002;
            5'd30: r = 36'sh000000001;
            default: r = '0;
         endcase
         return r;
      end
   endfunction

   // round half up q.30 product back to q.30
   function automatic logic signed [35:0] mulq(input logic signed [35:0] a,
                                               input logic signed [35:0] b);
      logic signed [71:0] p;
      begin
         p = 72'(a) * 72'(b) + 72'sd536870912;
         return 36'(p >>> 30);
      end
   endfunction

   // q.30 to q16.16 with round half up and saturation
   function automatic logic signed [31:0] to_q16(input logic signed [37:0] v);
      logic signed [37:0] t;
      begin
         t = (v + 38'sd8192) >>> 14;
         if (t > 38'sd2147483647) return 32'sh7FFFFFFF;
         else if (t < -38'sd2147483648) return 32'sh80000000;
         else return t[31:0];
      end
   endfunction

endpackage

FILE: src/rotation_vector_to_pose_matrix.sv
// top level: rotation vector plus translation to a 4x4 pose matrix
// uses rvpm_pkg, rvpm_sqrt, rvpm_trig and rvpm_matrix
//
// usage:
//   raise start with a pose on req_item while busy is low; the item is taken
//   at that edge. the block then holds busy while its spacing counter runs
//   down, so it takes no new pose until the counter is back at zero.
//   results come on rsp_item, one matrix row per cycle, four rows in all,
//   each marked by rsp_strobe: rows 0..2 carry the rotation entries and
//   the translation, row 3 is 0,0,0,1 with last_row set.
//   on the way to the first row a pose passes 33 square root stages, 32
//   divider/cordic stages, 2 product stages and the row shifter.
//   up to 17 poses sit in the stages ahead of the row shifter, and one more in it.
//   reset clears all valid bits and the busy counter; no pose survives it.
//   the receiver cannot stall: a row must be taken in the cycle it shows.
module rotation_vector_to_pose_matrix
   import rvpm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_strobe,
   output rsp_item_type rsp_item
);

   // spacing counter: keeps poses apart so all four rows of a matrix leave first
   logic [1:0] gap_ff;
   logic       take;
   assign take = start && !busy;
   assign busy = (gap_ff != '0);
   always_ff @(posedge clock) begin
      if (reset) gap_ff <= '0;
      else if (take) gap_ff <= 2'd3;
      else if (gap_ff != '0) gap_ff <= gap_ff - 2'd1;
   end

   logic               s_vld, s_zero;
   req_item_type       s_itm;
   logic [31:0]        s_root;
   rvpm_sqrt u_sqrt (
      .clock, .reset, .in_valid(take), .in_item(req_item),
      .out_valid(s_vld), .out_item(s_itm), .out_zero(s_zero), .out_root(s_root)
   );

   logic               t_vld;
   req_item_type       t_itm;
   logic signed [35:0] t_nx, t_ny, t_nz, t_sin, t_cos;
   rvpm_trig u_trig (
      .clock, .reset, .in_valid(s_vld), .in_item(s_itm), .in_zero(s_zero),
      .in_root(s_root), .out_valid(t_vld), .out_item(t_itm),
      .out_nx(t_nx), .out_ny(t_ny), .out_nz(t_nz), .out_sin(t_sin), .out_cos(t_cos)
   );

   rvpm_matrix u_matrix (
      .clock, .reset, .in_valid(t_vld), .in_item(t_itm),
      .in_nx(t_nx), .in_ny(t_ny), .in_nz(t_nz), .in_sin(t_sin), .in_cos(t_cos),
      .rsp_strobe, .rsp_item
   );

endmodule

FILE: src/rvpm_sqrt.sv
// pipelined integer square root and magnitude stage
// one restoring step per register stage after the entry stage; uses rvpm_pkg
module rvpm_sqrt
   import rvpm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  req_item_type       in_item,
   output logic               out_valid,
   output req_item_type       out_item,
   output logic               out_zero,
   output logic [31:0]        out_root
);

   // stage registers, index 0 is the entry stage
   logic         vld_ff  [0:SQRT_STEPS];
   req_item_type itm_ff  [0:SQRT_STEPS];
   logic [32:0]  rem_ff  [0:SQRT_STEPS];
   logic [31:0]  root_ff [0:SQRT_STEPS];
   logic [63:0]  rad_ff  [0:SQRT_STEPS];

   // squared norm at entry, at most three times 2^30 so no carry out
   logic [31:0] sx, sy, sz;
   logic [31:0] sq_in;
   always_comb begin
      sx = 32'($signed(in_item.rot_x) * $signed(in_item.rot_x));
      sy = 32'($signed(in_item.rot_y) * $signed(in_item.rot_y));
      sz = 32'($signed(in_item.rot_z) * $signed(in_item.rot_z));
      sq_in = sx + sy + sz;
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff[0] <= 1'b0;
      else       vld_ff[0] <= in_valid;
      itm_ff[0]  <= in_item;
      rem_ff[0]  <= '0;
      root_ff[0] <= '0;
      rad_ff[0]  <= {sq_in, 32'd0};
   end

   // one root bit per stage: radicand sq<<32 is 64 bits, root is 32 bits
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      logic [34:0] trial;
      logic [34:0] rem_next;
      logic        ok;
      always_comb begin
         rem_next = {rem_ff[k], rad_ff[k][63:62]};
         trial    = {1'b0, root_ff[k], 2'b01};
         ok       = rem_next >= trial;
      end
      always_ff @(posedge clock) begin
         if (reset) vld_ff[k+1] <= 1'b0;
         else       vld_ff[k+1] <= vld_ff[k];
         itm_ff[k+1]  <= itm_ff[k];
         rem_ff[k+1]  <= ok ? 33'(rem_next - trial) : rem_next[32:0];
         root_ff[k+1] <= {root_ff[k][30:0], ok};
         rad_ff[k+1]  <= {rad_ff[k][61:0], 2'b00};
      end
   end

   assign out_valid = vld_ff[SQRT_STEPS];
   assign out_item  = itm_ff[SQRT_STEPS];
   assign out_root  = root_ff[SQRT_STEPS];
   assign out_zero  = (root_ff[SQRT_STEPS] == '0);

endmodule

FILE: src/rvpm_trig.sv
// pipelined unit-axis divider and sine/cosine cordic
// restoring division and cordic rotation one step per stage; uses rvpm_pkg
module rvpm_trig
   import rvpm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  req_item_type       in_item,
   input  logic               in_zero,
   input  logic [31:0]        in_root,
   output logic               out_valid,
   output req_item_type       out_item,
   output logic signed [35:0] out_nx,
   output logic signed [35:0] out_ny,
   output logic signed [35:0] out_nz,
   output logic signed [35:0] out_sin,
   output logic signed [35:0] out_cos
);

   localparam int NS = DIV_STEPS;

   logic               vld_ff  [0:NS];
   req_item_type       itm_ff  [0:NS];
   logic               zro_ff  [0:NS];
   logic [31:0]        dvs_ff  [0:NS];
   logic [31:0]        rem_ff  [0:NS][0:2];
   logic [30:0]        quo_ff  [0:NS][0:2];
   logic               neg_ff  [0:NS][0:2];
   logic signed [35:0] cx_ff   [0:NS];
   logic signed [35:0] cy_ff   [0:NS];
   logic signed [35:0] cz_ff   [0:NS];
   logic               flip_ff [0:NS];

   // entry: magnitudes and angle range reduction
   logic signed [15:0] rin [0:2];
   logic [15:0]        mag [0:2];
   logic signed [35:0] z0, z1;
   logic               flip0;
   always_comb begin
      rin[0] = in_item.rot_x;
      rin[1] = in_item.rot_y;
      rin[2] = in_item.rot_z;
      for (int j = 0; j < 3; j++) begin
         mag[j] = 16'(rin[j][15] ? -17'(rin[j]) : 17'(rin[j]));
      end
      z0 = $signed({3'd0, in_root, 1'b0});
      if (z0 > PI30) z0 = z0 - TWOPI30;
      flip0 = 1'b0;
      z1 = z0;
      if (z0 > HALFPI30) begin
         z1 = z0 - PI30;
         flip0 = 1'b1;
      end else if (z0 < -HALFPI30) begin
         z1 = z0 + PI30;
         flip0 = 1'b1;
      end
   end

   // quotient of |r|<<46 by the root is below 2^31, so the division starts
   // with |r|<<15 as the partial remainder and needs only 31 steps
   always_ff @(posedge clock) begin
      if (reset) vld_ff[0] <= 1'b0;
      else       vld_ff[0] <= in_valid;
      itm_ff[0]  <= in_item;
      zro_ff[0]  <= in_zero;
      dvs_ff[0]  <= in_root;
      cx_ff[0]   <= CORDIC_GAIN;
      cy_ff[0]   <= '0;
      cz_ff[0]   <= z1;
      flip_ff[0] <= flip0;
      for (int j = 0; j < 3; j++) begin
         rem_ff[0][j] <= {1'b0, mag[j], 15'd0};
         quo_ff[0][j] <= '0;
         neg_ff[0][j] <= rin[j][15];
      end
   end

   // per stage: one quotient bit per component, one cordic step for the first 31
   for (genvar k = 0; k < NS; k++) begin : g_step
      logic [32:0] rsh [0:2];
      logic        ge  [0:2];
      logic signed [35:0] xs, ys, at;
      always_comb begin
         for (int j = 0; j < 3; j++) begin
            rsh[j] = {rem_ff[k][j], 1'b0};
            ge[j]  = rsh[j] >= {1'b0, dvs_ff[k]};
         end
         xs = cx_ff[k] >>> k;
         ys = cy_ff[k] >>> k;
         at = atan_entry(5'(k));
      end
      always_ff @(posedge clock) begin
         if (reset) vld_ff[k+1] <= 1'b0;
         else       vld_ff[k+1] <= vld_ff[k];
         itm_ff[k+1]  <= itm_ff[k];
         zro_ff[k+1]  <= zro_ff[k];
         dvs_ff[k+1]  <= dvs_ff[k];
         flip_ff[k+1] <= flip_ff[k];
         for (int j = 0; j < 3; j++) begin
            rem_ff[k+1][j] <= ge[j] ? 32'(rsh[j] - {1'b0, dvs_ff[k]}) : rsh[j][31:0];
            quo_ff[k+1][j] <= {quo_ff[k][j][29:0], ge[j]};
            neg_ff[k+1][j] <= neg_ff[k][j];
         end
         if (k < CORDIC_STEPS) begin
            if (cz_ff[k] >= 0) begin
               cx_ff[k+1] <= cx_ff[k] - ys;
               cy_ff[k+1] <= cy_ff[k] + xs;
               cz_ff[k+1] <= cz_ff[k] - at;
            end else begin
               cx_ff[k+1] <= cx_ff[k] + ys;
               cy_ff[k+1] <= cy_ff[k] - xs;
               cz_ff[k+1] <= cz_ff[k] + at;
            end
         end else begin
            cx_ff[k+1] <= cx_ff[k];
            cy_ff[k+1] <= cy_ff[k];
            cz_ff[k+1] <= cz_ff[k];
         end
      end
   end

   // output: sign, zero-vector override
   logic signed [35:0] n [0:2];
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         n[j] = neg_ff[NS][j] ? -$signed({5'd0, quo_ff[NS][j]})
                              : $signed({5'd0, quo_ff[NS][j]});
         if (zro_ff[NS]) n[j] = '0;
      end
   end

   assign out_valid = vld_ff[NS];
   assign out_item  = itm_ff[NS];
   assign out_nx    = n[0];
   assign out_ny    = n[1];
   assign out_nz    = n[2];
   assign out_sin   = zro_ff[NS] ? '0 : (flip_ff[NS] ? -cy_ff[NS] : cy_ff[NS]);
   assign out_cos   = zro_ff[NS] ? ONE30 : (flip_ff[NS] ? -cx_ff[NS] : cx_ff[NS]);

endmodule

FILE: src/rvpm_matrix.sv
// rodrigues matrix assembly and row serializer
// product stages a and b, a combinational sum stage c, then a four-row output queue; uses rvpm_pkg
module rvpm_matrix
   import rvpm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  req_item_type       in_item,
   input  logic signed [35:0] in_nx,
   input  logic signed [35:0] in_ny,
   input  logic signed [35:0] in_nz,
   input  logic signed [35:0] in_sin,
   input  logic signed [35:0] in_cos,
   output logic               rsp_strobe,
   output rsp_item_type       rsp_item
);

   // stage a: pair products and sine products
   logic               a_vld_ff;
   req_item_type       a_itm_ff;
   logic signed [35:0] a_xx_ff, a_yy_ff, a_zz_ff, a_xy_ff, a_xz_ff, a_yz_ff;
   logic signed [35:0] a_xs_ff, a_ys_ff, a_zs_ff, a_c_ff, a_v_ff;
   always_ff @(posedge clock) begin
      if (reset) a_vld_ff <= 1'b0;
      else       a_vld_ff <= in_valid;
      a_itm_ff <= in_item;
      a_xx_ff  <= mulq(in_nx, in_nx);
      a_yy_ff  <= mulq(in_ny, in_ny);
      a_zz_ff  <= mulq(in_nz, in_nz);
      a_xy_ff  <= mulq(in_nx, in_ny);
      a_xz_ff  <= mulq(in_nx, in_nz);
      a_yz_ff  <= mulq(in_ny, in_nz);
      a_xs_ff  <= mulq(in_nx, in_sin);
      a_ys_ff  <= mulq(in_ny, in_sin);
      a_zs_ff  <= mulq(in_nz, in_sin);
      a_c_ff   <= in_cos;
      a_v_ff   <= ONE30 - in_cos;
   end

   // stage b: scale by one minus cosine
   logic               b_vld_ff;
   req_item_type       b_itm_ff;
   logic signed [35:0] b_xx_ff, b_yy_ff, b_zz_ff, b_xy_ff, b_xz_ff, b_yz_ff;
   logic signed [35:0] b_xs_ff, b_ys_ff, b_zs_ff, b_c_ff;
   always_ff @(posedge clock) begin
      if (reset) b_vld_ff <= 1'b0;
      else       b_vld_ff <= a_vld_ff;
      b_itm_ff <= a_itm_ff;
      b_xx_ff  <= mulq(a_xx_ff, a_v_ff);
      b_yy_ff  <= mulq(a_yy_ff, a_v_ff);
      b_zz_ff  <= mulq(a_zz_ff, a_v_ff);
      b_xy_ff  <= mulq(a_xy_ff, a_v_ff);
      b_xz_ff  <= mulq(a_xz_ff, a_v_ff);
      b_yz_ff  <= mulq(a_yz_ff, a_v_ff);
      b_xs_ff  <= a_xs_ff;
      b_ys_ff  <= a_ys_ff;
      b_zs_ff  <= a_zs_ff;
      b_c_ff   <= a_c_ff;
   end

   // stage c: sums, rounding to q16.16, building the four rows
   rsp_item_type rows_in [0:3];
   always_comb begin
      rows_in[0] = '{2'd0,
         to_q16(38'(b_c_ff) + 38'(b_xx_ff)), to_q16(38'(b_xy_ff) - 38'(b_zs_ff)),
         to_q16(38'(b_ys_ff) + 38'(b_xz_ff)), b_itm_ff.trans_x, 1'b0};
      rows_in[1] = '{2'd1,
         to_q16(38'(b_zs_ff) + 38'(b_xy_ff)), to_q16(38'(b_c_ff) + 38'(b_yy_ff)),
         to_q16(38'(b_yz_ff) - 38'(b_xs_ff)), b_itm_ff.trans_y, 1'b0};
      rows_in[2] = '{2'd2,
         to_q16(38'(b_xz_ff) - 38'(b_ys_ff)), to_q16(38'(b_xs_ff) + 38'(b_yz_ff)),
         to_q16(38'(b_c_ff) + 38'(b_zz_ff)), b_itm_ff.trans_z, 1'b0};
      rows_in[3] = '{2'd3, 32'sd0, 32'sd0, 32'sd0, Q16_ONE, 1'b1};
   end

   // row shifter: loads a whole matrix, emits one row per cycle
   rsp_item_type rows_ff [0:3];
   logic [2:0]   cnt_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (b_vld_ff) begin
         cnt_ff <= 3'd4;
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 3'd1;
      end
      if (b_vld_ff) begin
         for (int j = 0; j < 4; j++) rows_ff[j] <= rows_in[j];
      end else begin
         for (int j = 0; j < 3; j++) rows_ff[j] <= rows_ff[j+1];
         rows_ff[3] <= rows_ff[3];
      end
   end

   assign rsp_strobe = (cnt_ff != '0);
   assign rsp_item   = rows_ff[0];

endmodule
